FILE: rtl/core/bhpd_pkg.sv
package bhpd_pkg;

	localparam int LEVEL_W = 14;
	localparam int NOW_W = 32;
	localparam int HOLD_W = 16;
	localparam int INDEX_W = 4;
	localparam logic [HOLD_W-1:0] MIN_HOLD_RESET = 16'd100;

	typedef enum logic [2:0] {
		PH_UNKNOWN = 3'b001,
		PH_UP      = 3'b010,
		PH_DOWN    = 3'b100
	} phase_t;

	typedef struct packed {
		logic               valid;
		logic [INDEX_W-1:0] index;
	} press_t;

endpackage

FILE: rtl/core/bhpd_if.sv
interface bhpd_poll_if
	import bhpd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] levels;
	logic [NOW_W-1:0]   now_ms;

	modport source(output valid, levels, now_ms, input ready);
	modport sink(input valid, levels, now_ms, output ready);
endinterface

interface bhpd_press_if
	import bhpd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               press_valid;
	logic [INDEX_W-1:0] press_index;

	modport source(output valid, press_valid, press_index, input ready);
	modport sink(input valid, press_valid, press_index, output ready);
endinterface

FILE: rtl/core/bhpd_lane.sv
module bhpd_lane
	import bhpd_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 up,
	input  logic [TIME_BITS-1:0] now,
	input  logic [HOLD_W-1:0]    min_hold,
	input  logic                 clear,
	output logic                 fire
);

	localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

	phase_t               phase_q;
	phase_t               phase_d;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] start_d;
	logic [TIME_BITS-1:0] held;

	// wrap-around elapsed time since the press began
	assign held = now - start_q;
	assign fire = (phase_q == PH_DOWN) && !up &&
		(CMP_W'(held) >= CMP_W'(min_hold));

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		unique case (phase_q)
			PH_DOWN: begin
				if (up) begin
					phase_d = PH_UP;
					start_d = '0;
				end
			end
			PH_UP: begin
				if (!up) begin
					phase_d = PH_DOWN;
					start_d = now;
				end
			end
			default: begin
				// arm only once seen released
				phase_d = up ? PH_UP : PH_UNKNOWN;
			end
		endcase
		if (clear) begin
			phase_d = PH_UNKNOWN;
			start_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_UNKNOWN;
			start_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			start_q <= start_d;
		end
	end

	a_clear_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && clear |=> phase_q == PH_UNKNOWN)
		else $error("lane not disarmed after a press fired");

	a_press_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !clear && phase_q == PH_UP && !up
		|=> phase_q == PH_DOWN && start_q == $past(now))
		else $error("press start not recorded");

	a_fire_needs_down: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fire |-> clear)
		else $error("lane fired without the merge clearing");

endmodule

FILE: rtl/core/bhpd_merge.sv
module bhpd_merge
	import bhpd_pkg::*;
#(
	parameter int BUTTON_COUNT = 14
) (
	input  logic [BUTTON_COUNT-1:0] fire,
	output press_t                  press
);

	// lowest index wins
	always_comb begin
		press = '0;
		for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
			if (fire[i]) begin
				press.valid = 1'b1;
				press.index = INDEX_W'(i);
			end
		end
	end

endmodule

FILE: rtl/core/button_hold_press_detector.sv
// Button hold press detector.
// poll (sink): one word per poll carries the raw level of every button
// (1 = released) and the current millisecond time. press (source): one word
// per poll, press_valid high when a button held down for at least
// min_hold_ms fired, with the lowest such index in press_index.
// cfg_we/cfg_data write min_hold_ms; write it only while the block is idle.
// Every button runs in its own lane; the lanes update their phase and start
// time at the edge a poll is taken, and a priority merge picks the winner.
// When any button fires, every lane returns to unknown.
// The result appears in the cycle after its poll is accepted, from an
// output register. One poll per cycle while the receiver keeps up; the lane
// state update closes within that cycle.
// A poll is taken whenever the output register is empty or being drained,
// so a stalled receiver holds the result and stops polls after one word.
// Reset: all buttons unknown, start times zero, min_hold_ms 100, output empty.
module button_hold_press_detector
	import bhpd_pkg::*;
#(
	parameter int BUTTON_COUNT = 14,
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	bhpd_poll_if.sink         poll,
	bhpd_press_if.source      press,
	input  logic              cfg_we,
	input  logic [HOLD_W-1:0] cfg_data
);

	logic [HOLD_W-1:0]       min_hold_q;
	logic                    in_acc;
	logic [BUTTON_COUNT-1:0] fire;
	press_t                  merged;
	logic                    valid_s1;
	press_t                  press_s1;

	assign poll.ready = !valid_s1 || press.ready;
	assign in_acc = poll.valid && poll.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hold_q <= MIN_HOLD_RESET;
		end else if (cfg_we) begin
			min_hold_q <= cfg_data;
		end
	end

	for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
		logic up;
		if (g < LEVEL_W) begin : g_pin
			assign up = poll.levels[g];
		end else begin : g_nopin
			// no pin: reads as pressed
			assign up = 1'b0;
		end
		bhpd_lane #(.TIME_BITS(TIME_BITS)) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.accept(in_acc),
			.up(up),
			.now(poll.now_ms[TIME_BITS-1:0]),
			.min_hold(min_hold_q),
			.clear(merged.valid),
			.fire(fire[g])
		);
	end

	bhpd_merge #(.BUTTON_COUNT(BUTTON_COUNT)) u_merge (
		.fire(fire),
		.press(merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			press_s1 <= merged;
		end
	end

	assign press.valid = valid_s1;
	assign press.press_valid = press_s1.valid;
	assign press.press_index = press_s1.index;

	a_poll_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted poll produced no result word");

	a_fire_reported: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (fire != '0) |=> press_s1.valid)
		else $error("fired button not reported");

	a_idle_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !press_s1.valid |-> press_s1.index == '0)
		else $error("press_index not zero without a press");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !press.ready |=> valid_s1 && $stable(press_s1))
		else $error("result word lost under stall");

endmodule

FILE: verif/tb_button_hold_press_detector.sv
module tb_button_hold_press_detector
	import bhpd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LANES = LEVEL_W;
	localparam int RANDOM_PHASES = 7;
	localparam int POLLS_PER_PHASE = 250;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;

	localparam logic [HOLD_W-1:0] HOLD_PLAN [RANDOM_PHASES] = '{
		16'd100, 16'd0, 16'd65535, 16'd1, 16'd37, 16'd500, 16'd250
	};

	typedef enum logic {
		ROW_POLL,
		ROW_HOLD
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [HOLD_W-1:0]  hold;
		logic [LEVEL_W-1:0] levels;
		logic [NOW_W-1:0]   now_ms;
		logic               typed;
		press_t             want;
	} poll_row_t;

	localparam press_t NO_PRESS = '{1'b0, 4'd0};
	localparam int DIRECTED_ROWS = 26;

	localparam poll_row_t DIRECTED [DIRECTED_ROWS] = '{
		// arm every button, then hold button 0 across the threshold
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'd0, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFE, 32'd1000, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFE, 32'd1099, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFE, 32'd1100, 1'b0, NO_PRESS},
		// unknown and down: never arms
		'{ROW_POLL, 16'd0, 14'h0000, 32'd2000, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h0000, 32'd9000, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'd9001, 1'b1, NO_PRESS},
		// two buttons across the time wrap, lower index wins
		'{ROW_POLL, 16'd0, 14'h1FDF, 32'hFFFF_FFF0, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h1FDF, 32'h0000_0060, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'h0000_0061, 1'b1, NO_PRESS},
		// zero hold time
		'{ROW_HOLD, 16'd0, 14'h0000, 32'd0, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FF7, 32'h0000_0070, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FF7, 32'h0000_0070, 1'b0, NO_PRESS},
		// release clears the start time, then a re-press fires first
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'hFFFF_FFFF, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFB, 32'hFFFF_FFFF, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'd0, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFB, 32'd5, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h0000, 32'd5, 1'b0, NO_PRESS},
		// longest hold time
		'{ROW_HOLD, 16'd65535, 14'h0000, 32'd0, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'h0000_1000, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3F7F, 32'h0000_1000, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3F7F, 32'h0001_0FFE, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3F7F, 32'h0001_0FFF, 1'b0, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h3FFF, 32'd0, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h0000, 32'hFFFF_FF00, 1'b1, NO_PRESS},
		'{ROW_POLL, 16'd0, 14'h0000, 32'h0000_FEFF, 1'b0, NO_PRESS}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [HOLD_W-1:0] cfg_data;

	bhpd_poll_if poll_ch();
	bhpd_press_if press_ch();

	button_hold_press_detector dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll(poll_ch),
		.press(press_ch),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	phase_t            lane_phase [LANES];
	logic [NOW_W-1:0]  lane_start [LANES];
	logic [HOLD_W-1:0] hold_ms;

	press_t press_expected_q [$];
	press_t press_want;
	int     mismatches = 0;
	bit     idle_on = 1'b1;
	int     stalls_asked = 0;
	int     stalls_done = 0;

	function automatic void clear_lanes();
		for (int i = 0; i < LANES; i++) begin
			lane_phase[i] = PH_UNKNOWN;
			lane_start[i] = '0;
		end
	endfunction

	// one poll through every lane; the first lane to qualify wins and resets all
	function automatic press_t predict_press(input logic [LEVEL_W-1:0] lv,
			input logic [NOW_W-1:0] now);
		press_t res;
		logic [NOW_W-1:0] held;
		res = NO_PRESS;
		for (int i = 0; i < LANES; i++) begin
			case (lane_phase[i])
				PH_DOWN: begin
					if (!lv[i]) begin
						held = now - lane_start[i];
						if (held >= NOW_W'(hold_ms)) begin
							clear_lanes();
							res.valid = 1'b1;
							res.index = i[INDEX_W-1:0];
							return res;
						end
					end else begin
						lane_phase[i] = PH_UP;
						lane_start[i] = '0;
					end
				end
				PH_UP: begin
					if (!lv[i]) begin
						lane_phase[i] = PH_DOWN;
						lane_start[i] = now;
					end
				end
				default: begin
					lane_phase[i] = lv[i] ? PH_UP : PH_UNKNOWN;
				end
			endcase
		end
		return res;
	endfunction

	function automatic void flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
		end
	endfunction

	task automatic send_poll(input logic [LEVEL_W-1:0] lv, input logic [NOW_W-1:0] now,
			input bit typed, input press_t want);
		press_t pred;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			poll_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.levels <= lv;
		poll_ch.now_ms <= now;
		do @(posedge clk); while (!poll_ch.ready);
		pred = predict_press(lv, now);
		press_expected_q.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// drain every word before touching the register
	task automatic write_hold(input logic [HOLD_W-1:0] value);
		poll_ch.valid <= 1'b0;
		while (press_expected_q.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		hold_ms = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [LEVEL_W-1:0] down_mask;
		logic [NOW_W-1:0]   clock_ms;
		logic [HOLD_W-1:0]  hold;
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		poll_ch.valid = 1'b0;
		poll_ch.levels = '0;
		poll_ch.now_ms = '0;
		clear_lanes();
		hold_ms = MIN_HOLD_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int row = 0; row < DIRECTED_ROWS; row++) begin
			if (DIRECTED[row].kind == ROW_HOLD) begin
				write_hold(DIRECTED[row].hold);
			end else begin
				send_poll(DIRECTED[row].levels, DIRECTED[row].now_ms,
					DIRECTED[row].typed, DIRECTED[row].want);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			hold = (ph == RANDOM_PHASES - 1) ? HOLD_PLAN[ph] - HOLD_W'($urandom_range(0, 200))
				: HOLD_PLAN[ph];
			write_hold(hold);
			// no idling in the closing phase
			if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
			down_mask = '0;
			clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 4000);
			for (int n = 0; n < POLLS_PER_PHASE; n++) begin
				if ((ph == 2 || ph == 4) && n == 80) stalls_asked++;
				r = $urandom_range(0, 99);
				if (r < 20) begin
					down_mask ^= LEVEL_W'(1) << $urandom_range(0, LANES - 1);
				end else if (r < 24) begin
					down_mask = '0;
				end else if (r < 29) begin
					down_mask = LEVEL_W'($urandom);
				end
				clock_ms += $urandom_range(0, hold / 8 + 3);
				if ($urandom_range(0, 99) < 2) clock_ms = $urandom;
				send_poll(~down_mask, clock_ms, 1'b0, NO_PRESS);
			end
		end

		poll_ch.valid <= 1'b0;
		while (press_expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("button_hold_press_detector verification clean");
		end else begin
			$display("button_hold_press_detector verification failed");
		end
		$finish;
	end

	// receiver: random back-pressure, plus a long hold-off on request
	initial begin
		press_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_done < stalls_asked) begin
				stalls_done++;
				press_ch.ready <= 1'b0;
				repeat (LONG_STALL_CYCLES) @(negedge clk);
				press_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				press_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				press_ch.ready <= 1'b1;
			end else begin
				press_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && press_ch.valid && press_ch.ready) begin
			if (press_expected_q.size() == 0) begin
				flag_mismatch("unexpected word", 0, 1);
			end else begin
				press_want = press_expected_q.pop_front();
				if (press_ch.press_valid !== press_want.valid) begin
					flag_mismatch("press_valid", press_want.valid, press_ch.press_valid);
				end
				if (press_ch.press_index !== press_want.index) begin
					flag_mismatch("press_index", press_want.index, press_ch.press_index);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("button_hold_press_detector verification failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/bhpd_pkg.sv
rtl/core/bhpd_if.sv
rtl/core/bhpd_lane.sv
rtl/core/bhpd_merge.sv
rtl/core/button_hold_press_detector.sv
verif/tb_button_hold_press_detector.sv
